[rtl/sfgr_pkg.sv]
`default_nettype none

package sfgr_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SCALE_W     = 4;
  localparam int unsigned GRAY_W      = 8;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NUM_W       = 16;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned GLYPH_IDX_W = 6;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned DIGIT_PTR_W = $clog2(NUM_DIGITS);
  localparam int unsigned GLYPH_ROWS  = 5;
  localparam int unsigned ROW_W       = $clog2(GLYPH_ROWS);

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_SCALE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAY_LEVEL  = 1'd1;

  localparam logic [SCALE_W-1:0] PIXEL_SCALE_RESET = 4'd1;
  localparam logic [GRAY_W-1:0]  GRAY_LEVEL_RESET  = 8'd255;

  // Input modes.
  localparam logic MODE_TEXT   = 1'b0;
  localparam logic MODE_NUMBER = 1'b1;

  // Reciprocal of ten: (v * 52429) >> 19 equals v / 10 for every 16-bit v.
  localparam logic [15:0] DIV10_MAGIC = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // Letters follow the ten digits in the glyph index space.
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_LETTER_BASE = 6'd10;

  typedef logic [GLYPH_ROWS-1:0][2:0] glyph_t;

  typedef struct packed {
    logic                   ok;
    logic [GLYPH_IDX_W-1:0] idx;
  } glyph_sel_t;

  // Rows are given top to bottom; element zero of the result is the top row.
  function automatic glyph_t rows(input logic [2:0] r0, input logic [2:0] r1,
                                  input logic [2:0] r2, input logic [2:0] r3,
                                  input logic [2:0] r4);
    return {r4, r3, r2, r1, r0};
  endfunction

  function automatic glyph_t font_glyph(input logic [GLYPH_IDX_W-1:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = rows(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
      6'd1:  g = rows(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
      6'd2:  g = rows(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
      6'd3:  g = rows(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
      6'd4:  g = rows(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
      6'd5:  g = rows(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
      6'd6:  g = rows(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
      6'd7:  g = rows(3'd7, 3'd1, 3'd1, 3'd1, 3'd1);
      6'd8:  g = rows(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
      6'd9:  g = rows(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
      6'd10: g = rows(3'd7, 3'd5, 3'd7, 3'd5, 3'd5);
      6'd11: g = rows(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
      6'd12: g = rows(3'd7, 3'd4, 3'd4, 3'd4, 3'd7);
      6'd13: g = rows(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
      6'd14: g = rows(3'd7, 3'd4, 3'd7, 3'd4, 3'd7);
      6'd15: g = rows(3'd7, 3'd4, 3'd7, 3'd4, 3'd4);
      6'd16: g = rows(3'd7, 3'd4, 3'd5, 3'd5, 3'd7);
      6'd17: g = rows(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
      6'd18: g = rows(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
      6'd19: g = rows(3'd7, 3'd1, 3'd1, 3'd5, 3'd7);
      6'd20: g = rows(3'd5, 3'd6, 3'd4, 3'd6, 3'd5);
      6'd21: g = rows(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
      6'd22: g = rows(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
      6'd23: g = rows(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
      6'd24: g = rows(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
      6'd25: g = rows(3'd7, 3'd5, 3'd7, 3'd4, 3'd4);
      6'd26: g = rows(3'd7, 3'd5, 3'd5, 3'd7, 3'd1);
      6'd27: g = rows(3'd7, 3'd5, 3'd6, 3'd5, 3'd5);
      6'd28: g = rows(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
      6'd29: g = rows(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
      6'd30: g = rows(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
      6'd31: g = rows(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
      6'd32: g = rows(3'd5, 3'd5, 3'd7, 3'd7, 3'd5);
      6'd33: g = rows(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
      6'd34: g = rows(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
      6'd35: g = rows(3'd7, 3'd1, 3'd2, 3'd4, 3'd7);
      default: g = '0;
    endcase
    return g;
  endfunction

  // Maps an ASCII code to a glyph; lower case folds onto the capitals.
  function automatic glyph_sel_t char_glyph(input logic [CHAR_W-1:0] code);
    glyph_sel_t s;
    logic [CHAR_W-1:0] off;
    off = '0;
    s.ok = 1'b1;
    if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9) begin
      off = code - CHAR_DIGIT_0;
      s.idx = off[GLYPH_IDX_W-1:0];
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      off = code - CHAR_UPPER_A;
      s.idx = off[GLYPH_IDX_W-1:0] + GLYPH_LETTER_BASE;
    end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      off = code - CHAR_LOWER_A;
      s.idx = off[GLYPH_IDX_W-1:0] + GLYPH_LETTER_BASE;
    end else begin
      s.ok = 1'b0;
      s.idx = '0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/sfgr_if.sv]
`default_nettype none

// Request channel: one character or one number per word.
interface sfgr_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [sfgr_pkg::CHAR_W-1:0]  char_code;
  logic [sfgr_pkg::NUM_W-1:0]   number_value;
  logic [sfgr_pkg::COORD_W-1:0] start_x;
  logic [sfgr_pkg::COORD_W-1:0] start_y;
  logic                         first_char;

  modport source (output valid, mode, char_code, number_value, start_x, start_y,
                  first_char, input ready);
  modport sink (input valid, mode, char_code, number_value, start_x, start_y,
                first_char, output ready);
endinterface

// Block channel: one scaled pixel block per word.
interface sfgr_blk_if;
  logic                         valid;
  logic                         ready;
  logic [sfgr_pkg::COORD_W-1:0] block_x;
  logic [sfgr_pkg::COORD_W-1:0] block_y;
  logic [sfgr_pkg::SCALE_W-1:0] block_size;
  logic [sfgr_pkg::GRAY_W-1:0]  block_gray;
  logic                         last_block;

  modport source (output valid, block_x, block_y, block_size, block_gray, last_block,
                  input ready);
  modport sink (input valid, block_x, block_y, block_size, block_gray, last_block,
                output ready);
endinterface

`default_nettype wire

[rtl/scaled_font_glyph_renderer_top.sv]
// Scaled 3x5 font character generator.
// The req channel takes one word per character (text mode) or per 16-bit value
// (number mode); the blk channel gives one word per lit font cell: the top-left
// corner, side length and gray level of a square block, with last_block set on
// the final block that a request causes. Requests that light no cell (space,
// unsupported codes, zero scale in text mode) give no words at all.
// Configuration (pixel_scale, gray_level) is written through cfg_we, cfg_index
// and cfg_data. The user must write it only while the block is idle; the
// block itself does not enforce this.
// Timing: a text character is taken and its glyph is then scanned one font
// cell per cycle unless a lit cell must wait for a stalled receiver; req.ready
// stays low until the scan ends. A number first finds its decimal digits in
// the divide-by-ten step (a reciprocal multiply) and then scans the glyph of
// each digit, up to five digits. Characters with no glyph are taken without a
// scan. The cell scan is the rate-setting loop. A lit cell reaches blk in
// the cycle after it is scanned; scanning starts once the request is latched.
// If the receiver stalls, the scan halts on the next lit cell until the output
// register is free; unlit cells are skipped without waiting.
// Reset restores pixel_scale 1 and gray_level 255, clears the text cursor and
// drops any block that was waiting on blk.
`default_nettype none

module scaled_font_glyph_renderer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [sfgr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfgr_pkg::CFG_DATA_W-1:0]  cfg_data,
  sfgr_req_if.sink                              req,
  sfgr_blk_if.source                            blk
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DRAW = 3'b100
  } state_t;

  state_t state;

  // Configuration and persistent text cursor.
  logic [sfgr_pkg::SCALE_W-1:0] pixel_scale;
  logic [sfgr_pkg::GRAY_W-1:0]  gray_level;
  logic [sfgr_pkg::COORD_W-1:0] pen_x;
  logic [sfgr_pkg::COORD_W-1:0] line_y;

  // Working registers of the current request.
  logic [sfgr_pkg::SCALE_W-1:0]     scale;
  logic [sfgr_pkg::GLYPH_IDX_W-1:0] glyph_idx;
  logic [sfgr_pkg::ROW_W-1:0]       row;
  logic [1:0]                       col;
  logic [sfgr_pkg::COORD_W-1:0]     cell_x;
  logic [sfgr_pkg::COORD_W-1:0]     cell_y;
  logic [sfgr_pkg::COORD_W-1:0]     glyph_x;
  logic [sfgr_pkg::COORD_W-1:0]     base_y;
  logic [sfgr_pkg::DIGIT_PTR_W-1:0] dig_ptr;
  logic [3:0]                       digits [sfgr_pkg::NUM_DIGITS];
  logic [sfgr_pkg::NUM_W-1:0]       div_t;
  logic [sfgr_pkg::DIGIT_PTR_W-1:0] div_cnt;

  // Output register.
  logic                         out_valid;
  logic [sfgr_pkg::COORD_W-1:0] out_x;
  logic [sfgr_pkg::COORD_W-1:0] out_y;
  logic [sfgr_pkg::SCALE_W-1:0] out_size;
  logic [sfgr_pkg::GRAY_W-1:0]  out_gray;
  logic                         out_last;

  // Request decode.
  logic                         req_take;
  logic [sfgr_pkg::COORD_W-1:0] eff_x;
  logic [sfgr_pkg::COORD_W-1:0] eff_y;
  sfgr_pkg::glyph_sel_t         req_glyph;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign eff_x     = req.first_char ? req.start_x : pen_x;
  assign eff_y     = req.first_char ? req.start_y : line_y;
  assign req_glyph = sfgr_pkg::char_glyph(req.char_code);

  // Divide-by-ten step: one decimal digit per cycle, least significant first.
  logic [31:0]                div_prod;
  logic [12:0]                div_q;
  logic [sfgr_pkg::NUM_W-1:0] div_q10;
  logic [sfgr_pkg::NUM_W-1:0] div_rem;
  logic [3:0]                 div_digit;

  assign div_prod  = div_t * sfgr_pkg::DIV10_MAGIC;
  assign div_q     = div_prod[31:sfgr_pkg::DIV10_SHIFT];
  assign div_q10   = 16'({div_q, 3'b000}) + 16'({div_q, 1'b0});
  assign div_rem   = div_t - div_q10;
  assign div_digit = div_rem[3:0];

  // Cell scan.
  sfgr_pkg::glyph_t             glyph;
  logic [2:0]                   row_bits;
  logic [1:0]                   bit_pos;
  logic [2:0]                   right_mask;
  logic                         lit;
  logic                         last_cell;
  logic                         can_step;
  logic                         emit;
  logic [sfgr_pkg::COORD_W-1:0] step;
  logic [sfgr_pkg::COORD_W-1:0] advance;
  logic [sfgr_pkg::DIGIT_PTR_W-1:0] dig_prev;

  assign glyph      = sfgr_pkg::font_glyph(glyph_idx);
  assign row_bits   = glyph[row];
  assign bit_pos    = 2'd2 - col;
  assign lit        = row_bits[bit_pos];
  // Cells to the right of the current column within the row.
  assign right_mask = (3'b001 << bit_pos) - 3'b001;
  // Every glyph has a lit bottom row, so the final block of the final glyph is
  // the rightmost lit cell of row four.
  assign last_cell  = (dig_ptr == '0) && (row == 3'(sfgr_pkg::GLYPH_ROWS - 1)) &&
                      ((row_bits & right_mask) == 3'b000);
  assign can_step   = !lit || !out_valid || blk.ready;
  // A lit cell is loaded into the output register on this edge.
  assign emit       = (state == ST_DRAW) && can_step && lit;
  assign step       = 16'(scale);
  assign advance    = 16'({scale, 2'b00});
  assign dig_prev   = dig_ptr - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pixel_scale <= sfgr_pkg::PIXEL_SCALE_RESET;
      gray_level  <= sfgr_pkg::GRAY_LEVEL_RESET;
      pen_x       <= '0;
      line_y      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfgr_pkg::REG_PIXEL_SCALE: pixel_scale <= cfg_data[sfgr_pkg::SCALE_W-1:0];
          sfgr_pkg::REG_GRAY_LEVEL:  gray_level  <= cfg_data;
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && blk.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_take) begin
            row     <= '0;
            col     <= '0;
            dig_ptr <= '0;
            if (req.mode == sfgr_pkg::MODE_TEXT) begin
              // A restart takes the start position even when the scale hides
              // the text; at a nonzero scale every character, spaces too, moves the cursor on.
              pen_x <= (pixel_scale != '0) ? eff_x + 16'({pixel_scale, 2'b00}) : eff_x;
              if (req.first_char) begin
                line_y <= req.start_y;
              end
              if (pixel_scale != '0 && req_glyph.ok) begin
                scale     <= pixel_scale;
                glyph_idx <= req_glyph.idx;
                cell_x    <= eff_x;
                glyph_x   <= eff_x;
                cell_y    <= eff_y;
                base_y    <= eff_y;
                state     <= ST_DRAW;
              end
            end else begin
              scale   <= (pixel_scale == '0) ? 4'd1 : pixel_scale;
              div_t   <= req.number_value;
              div_cnt <= '0;
              cell_x  <= req.start_x;
              glyph_x <= req.start_x;
              cell_y  <= req.start_y;
              base_y  <= req.start_y;
              state   <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          digits[div_cnt] <= div_digit;
          if (div_q == '0 || div_cnt == 3'(sfgr_pkg::NUM_DIGITS - 1)) begin
            // The digit found last is the leading one and is drawn first.
            glyph_idx <= 6'(div_digit);
            dig_ptr   <= div_cnt;
            state     <= ST_DRAW;
          end else begin
            div_cnt <= div_cnt + 3'd1;
            div_t   <= 16'(div_q);
          end
        end

        ST_DRAW: begin
          if (can_step) begin
            if (lit) begin
              out_x    <= cell_x;
              out_y    <= cell_y;
              out_size <= scale;
              out_gray <= gray_level;
              out_last <= last_cell;
            end
            if (col == 2'd2) begin
              col <= '0;
              if (row == 3'(sfgr_pkg::GLYPH_ROWS - 1)) begin
                row <= '0;
                if (dig_ptr == '0) begin
                  state <= ST_IDLE;
                end else begin
                  dig_ptr   <= dig_prev;
                  glyph_idx <= 6'(digits[dig_prev]);
                  glyph_x   <= glyph_x + advance;
                  cell_x    <= glyph_x + advance;
                  cell_y    <= base_y;
                end
              end else begin
                row    <= row + 3'd1;
                cell_x <= glyph_x;
                cell_y <= cell_y + step;
              end
            end else begin
              col    <= col + 2'd1;
              cell_x <= cell_x + step;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign blk.valid      = out_valid;
  assign blk.block_x    = out_x;
  assign blk.block_y    = out_y;
  assign blk.block_size = out_size;
  assign blk.block_gray = out_gray;
  assign blk.last_block = out_last;

endmodule

`default_nettype wire
